### rtl/core/tfq_pkg.sv
// Shared types and constants for the touch frame qualifier.
`timescale 1ns / 1ps
`default_nettype none
package tfq_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_ROTATION     = 3'd0;
  localparam logic [2:0] REG_PANEL_WIDTH  = 3'd1;
  localparam logic [2:0] REG_PANEL_HEIGHT = 3'd2;
  localparam logic [2:0] REG_HOLD_MS      = 3'd3;
  localparam logic [2:0] REG_JUMP_X       = 3'd4;
  localparam logic [2:0] REG_JUMP_Y       = 3'd5;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Configuration reset values
  localparam logic [1:0]  RST_ROTATION     = 2'd0;
  localparam logic [12:0] RST_PANEL_WIDTH  = 13'd320;
  localparam logic [12:0] RST_PANEL_HEIGHT = 13'd480;
  localparam logic [15:0] RST_HOLD_MS      = 16'd120;
  localparam logic [11:0] RST_JUMP_X       = 12'd120;
  localparam logic [11:0] RST_JUMP_Y       = 12'd40;

  // Event codes, byte 2 bits 7-6
  localparam logic [1:0] EV_DOWN    = 2'd0;
  localparam logic [1:0] EV_UP      = 2'd1;
  localparam logic [1:0] EV_CONTACT = 2'd2;

  // Rotation codes
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_CW   = 2'd1;
  localparam logic [1:0] ROT_FLIP = 2'd2;
  localparam logic [1:0] ROT_CCW  = 2'd3;

  // Frame classes handed from front to back
  localparam logic [1:0] CLS_KEEP  = 2'd0;  // hold, no state change
  localparam logic [1:0] CLS_UP    = 2'd1;  // release
  localparam logic [1:0] CLS_CLEAR = 2'd2;  // clear stability, then hold
  localparam logic [1:0] CLS_POINT = 2'd3;  // mapped point to qualify

  localparam logic [1:0] STABLE_MAX = 2'd3;
  localparam logic [1:0] STABLE_MIN = 2'd2;

  typedef struct packed {
    logic [1:0]  cls;
    logic        down;
    logic [31:0] time_ms;
  } frame_ctl_t;

  typedef struct packed {
    logic       contact_active;
    logic [1:0] stable_count;
  } back_status_t;

endpackage
`default_nettype wire

### rtl/core/tfq_front.sv
// Front end: decodes a frame, classifies it and maps the raw point to the panel.
`timescale 1ns / 1ps
`default_nettype none
module tfq_front #(
  parameter int COORD_BITS = 12
) (
  input  wire logic [1:0]            rotation,
  input  wire logic [12:0]           panel_width,
  input  wire logic [12:0]           panel_height,
  input  wire logic                  bus_ok,
  input  wire logic [7:0]            gesture_byte,
  input  wire logic [7:0]            point_count,
  input  wire logic [7:0]            event_x_high,
  input  wire logic [7:0]            x_low,
  input  wire logic [7:0]            y_high,
  input  wire logic [7:0]            y_low,
  input  wire logic [31:0]           time_ms,
  output tfq_pkg::frame_ctl_t        ctl,
  output logic [COORD_BITS-1:0]      map_x,
  output logic [COORD_BITS-1:0]      map_y
);
  import tfq_pkg::*;

  localparam logic [16:0] COORD_MAX = 17'((1 << COORD_BITS) - 1);

  logic [1:0]         ev;
  logic [11:0]        rx;
  logic [11:0]        ry;
  logic signed [14:0] rxs;
  logic signed [14:0] rys;
  logic signed [14:0] wm1;
  logic signed [14:0] hm1;
  logic signed [14:0] xs;
  logic signed [14:0] ys;
  logic [16:0]        lim_x;
  logic [16:0]        lim_y;
  logic               in_panel;

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [14:0] v,
                                                  input logic [16:0] lim);
    logic [16:0] u;
    u = {3'b000, v[13:0]};
    if (v[14]) begin
      clamp = '0;
    end else if (u > lim) begin
      clamp = lim[COORD_BITS-1:0];
    end else begin
      clamp = u[COORD_BITS-1:0];
    end
  endfunction

  assign ev  = event_x_high[7:6];
  assign rx  = {event_x_high[3:0], x_low};
  assign ry  = {y_high[3:0], y_low};
  assign rxs = $signed({3'b000, rx});
  assign rys = $signed({3'b000, ry});
  assign wm1 = $signed({2'b00, panel_width}) - 15'sd1;
  assign hm1 = $signed({2'b00, panel_height}) - 15'sd1;

  assign in_panel = ({1'b0, rx} < panel_height) && ({1'b0, ry} < panel_width);

  always_comb begin
    case (rotation)
      ROT_CW, ROT_CCW: begin
        xs = wm1 - rys;
        ys = rxs;
      end
      ROT_FLIP: begin
        xs = wm1 - rxs;
        ys = hm1 - rys;
      end
      default: begin
        xs = rxs;
        ys = rys;
      end
    endcase
  end

  // Panel limit, saturated to the coordinate range
  assign lim_x = ({4'b0, panel_width} - 17'd1 > COORD_MAX) ? COORD_MAX
               : {4'b0, panel_width} - 17'd1;
  assign lim_y = ({4'b0, panel_height} - 17'd1 > COORD_MAX) ? COORD_MAX
               : {4'b0, panel_height} - 17'd1;

  assign map_x = clamp(xs, lim_x);
  assign map_y = clamp(ys, lim_y);

  always_comb begin
    ctl.time_ms = time_ms;
    ctl.down    = (ev == EV_DOWN);
    if (!bus_ok) begin
      ctl.cls = CLS_KEEP;
    end else if (ev == EV_UP) begin
      ctl.cls = CLS_UP;
    end else if (gesture_byte != 8'h00 || point_count == 8'h00) begin
      ctl.cls = CLS_KEEP;
    end else if (ev != EV_DOWN && ev != EV_CONTACT) begin
      ctl.cls = CLS_CLEAR;
    end else if (!in_panel) begin
      ctl.cls = CLS_CLEAR;
    end else begin
      ctl.cls = CLS_POINT;
    end
  end

endmodule
`default_nettype wire

### rtl/core/tfq_queue.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module tfq_queue #(
  parameter int DATA_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [DATA_BITS-1:0] push_data,
  input  wire logic                 pop,
  output logic                      full,
  output logic                      head_valid,
  output logic [DATA_BITS-1:0]      head_data
);

  logic [DATA_BITS-1:0] entry [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/tfq_back.sv
// Back end: stability count, hold timing and the result register.
`timescale 1ns / 1ps
`default_nettype none
module tfq_back #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [15:0]             hold_ms,
  input  wire logic [11:0]             jump_x,
  input  wire logic [11:0]             jump_y,
  input  wire logic                    take,
  input  wire tfq_pkg::frame_ctl_t     ctl,
  input  wire logic [COORD_BITS-1:0]   map_x,
  input  wire logic [COORD_BITS-1:0]   map_y,
  input  wire logic                    result_stall,
  output logic                         result_valid,
  output logic                         touched,
  output logic [COORD_BITS-1:0]        point_x,
  output logic [COORD_BITS-1:0]        point_y,
  output tfq_pkg::back_status_t        status
);
  import tfq_pkg::*;

  logic [1:0]            stable_count;
  logic [1:0]            stable_count_next;
  logic                  contact_active;
  logic                  contact_active_next;
  logic [COORD_BITS-1:0] last_x;
  logic [COORD_BITS-1:0] last_x_next;
  logic [COORD_BITS-1:0] last_y;
  logic [COORD_BITS-1:0] last_y_next;
  logic [31:0]           last_time;
  logic [31:0]           last_time_next;
  logic                  res_touched;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  logic                  hold_live;
  logic [31:0]           age;
  logic [1:0]            count_up;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  jumped;

  assign age       = ctl.time_ms - last_time;
  assign hold_live = contact_active && (age <= {16'b0, hold_ms});

  assign dx = (map_x > last_x) ? map_x - last_x : last_x - map_x;
  assign dy = (map_y > last_y) ? map_y - last_y : last_y - map_y;
  assign jumped = (17'(dx) > 17'(jump_x)) || (17'(dy) > 17'(jump_y));

  always_comb begin
    if (ctl.down) begin
      count_up = 2'd1;
    end else if (stable_count == STABLE_MAX) begin
      count_up = STABLE_MAX;
    end else begin
      count_up = stable_count + 2'd1;
    end
  end

  always_comb begin
    stable_count_next   = stable_count;
    contact_active_next = contact_active;
    last_x_next         = last_x;
    last_y_next         = last_y;
    last_time_next      = last_time;
    res_touched         = hold_live;
    case (ctl.cls)
      CLS_UP: begin
        stable_count_next   = 2'd0;
        contact_active_next = 1'b0;
        res_touched         = 1'b0;
      end
      CLS_CLEAR: begin
        stable_count_next = 2'd0;
      end
      CLS_POINT: begin
        stable_count_next = jumped ? {1'b0, ctl.down} : count_up;
        last_x_next       = map_x;
        last_y_next       = map_y;
        if (!jumped && count_up >= STABLE_MIN) begin
          contact_active_next = 1'b1;
          last_time_next      = ctl.time_ms;
          res_touched         = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_x = res_touched ? last_x_next : '0;
    res_y = res_touched ? last_y_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_count   <= 2'd0;
      contact_active <= 1'b0;
      last_x         <= '0;
      last_y         <= '0;
      last_time      <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (take) begin
        stable_count   <= stable_count_next;
        contact_active <= contact_active_next;
        last_x         <= last_x_next;
        last_y         <= last_y_next;
        last_time      <= last_time_next;
        result_valid   <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      touched <= res_touched;
      point_x <= res_x;
      point_y <= res_y;
    end
  end

  assign status.contact_active = contact_active;
  assign status.stable_count   = stable_count;

endmodule
`default_nettype wire

### rtl/core/touch_frame_qualifier.sv
// Top level of the touch frame qualifier: configuration registers and datapath.
//
// Frame channel: frame_valid/frame_stall carry one polled controller frame per
// transfer (bus flag, six response bytes, millisecond time stamp).
// Result channel: result_valid/result_stall carry one result per frame:
// touched with point_x/point_y, coordinates zero when not touched.
// Configuration: cfg_we writes cfg_data into the register selected by
// cfg_index; write only while no frame is in flight.
// Path: an accepted frame is written into the queue, then taken from its
// head into the result register. Throughput: one frame per cycle when
// nothing is stalled, set by the stability/hold update in the back end.
// The front end classifies and maps the point in the accepting cycle and
// pushes into a two-entry queue; frame_stall rises only when it is full.
// Receiver stall holds the result register; the queue absorbs up to two more
// frames before frame_stall asserts.
// Reset: synchronous; clears the queue, the result valid flag and all touch
// state, and loads the default panel configuration.
`timescale 1ns / 1ps
`default_nettype none
module touch_frame_qualifier #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [tfq_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [tfq_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  wire logic                                  frame_valid,
  output logic                                       frame_stall,
  input  wire logic                                  bus_ok,
  input  wire logic [7:0]                            gesture_byte,
  input  wire logic [7:0]                            point_count,
  input  wire logic [7:0]                            event_x_high,
  input  wire logic [7:0]                            x_low,
  input  wire logic [7:0]                            y_high,
  input  wire logic [7:0]                            y_low,
  input  wire logic [31:0]                           time_ms,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic                                       touched,
  output logic [COORD_BITS-1:0]                      point_x,
  output logic [COORD_BITS-1:0]                      point_y
);
  import tfq_pkg::*;

  localparam int ITEM_BITS = $bits(frame_ctl_t) + 2 * COORD_BITS;

  logic [1:0]            rotation;
  logic [12:0]           panel_width;
  logic [12:0]           panel_height;
  logic [15:0]           hold_ms;
  logic [11:0]           jump_x;
  logic [11:0]           jump_y;

  frame_ctl_t            front_ctl;
  logic [COORD_BITS-1:0] front_x;
  logic [COORD_BITS-1:0] front_y;
  frame_ctl_t            head_ctl;
  logic [COORD_BITS-1:0] head_x;
  logic [COORD_BITS-1:0] head_y;
  logic [ITEM_BITS-1:0]  head_data;
  logic                  head_valid;
  logic                  q_full;
  logic                  push;
  logic                  take;
  back_status_t          back_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation     <= RST_ROTATION;
      panel_width  <= RST_PANEL_WIDTH;
      panel_height <= RST_PANEL_HEIGHT;
      hold_ms      <= RST_HOLD_MS;
      jump_x       <= RST_JUMP_X;
      jump_y       <= RST_JUMP_Y;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTATION:     rotation     <= cfg_data[1:0];
        REG_PANEL_WIDTH:  panel_width  <= cfg_data[12:0];
        REG_PANEL_HEIGHT: panel_height <= cfg_data[12:0];
        REG_HOLD_MS:      hold_ms      <= cfg_data;
        REG_JUMP_X:       jump_x       <= cfg_data[11:0];
        REG_JUMP_Y:       jump_y       <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  assign frame_stall = q_full;
  assign push        = frame_valid && !q_full;
  assign take        = head_valid && (!result_valid || !result_stall);

  tfq_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .rotation     (rotation),
    .panel_width  (panel_width),
    .panel_height (panel_height),
    .bus_ok       (bus_ok),
    .gesture_byte (gesture_byte),
    .point_count  (point_count),
    .event_x_high (event_x_high),
    .x_low        (x_low),
    .y_high       (y_high),
    .y_low        (y_low),
    .time_ms      (time_ms),
    .ctl          (front_ctl),
    .map_x        (front_x),
    .map_y        (front_y)
  );

  tfq_queue #(
    .DATA_BITS(ITEM_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({front_ctl, front_x, front_y}),
    .pop        (take),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign {head_ctl, head_x, head_y} = head_data;

  tfq_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .hold_ms      (hold_ms),
    .jump_x       (jump_x),
    .jump_y       (jump_y),
    .take         (take),
    .ctl          (head_ctl),
    .map_x        (head_x),
    .map_y        (head_y),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .touched      (touched),
    .point_x      (point_x),
    .point_y      (point_y),
    .status       (back_status)
  );

`ifndef SYNTHESIS
  // Release frames always produce an untouched result
  assert property (@(posedge clk) disable iff (rst)
    take && head_ctl.cls == CLS_UP |=> result_valid && !touched)
    else $error("release frame reported as touched");

  // A touched result implies contact is still active
  assert property (@(posedge clk) disable iff (rst)
    result_valid && touched |-> back_status.contact_active)
    else $error("touched result without active contact");

  // A release clears the stability count
  assert property (@(posedge clk) disable iff (rst)
    take && head_ctl.cls == CLS_UP |=> back_status.stable_count == 2'd0)
    else $error("stability count not cleared on release");

  // Untouched results carry zero coordinates
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !touched |-> point_x == '0 && point_y == '0)
    else $error("untouched result with nonzero coordinates");
`endif

endmodule
`default_nettype wire
